// File: design/cspb_pkg.sv
// ----------------------------------------------------------------------------
// cspb_pkg
// Shared types and constants of the clipped sprite blit addresser.
// ----------------------------------------------------------------------------
package cspb_pkg;

   // parameter defaults
   localparam int GFX_STORE_SIZE = 2097152;
   localparam int SHEET_COUNT    = 32;

   // pointer and sum width, enough for the largest graphics store (2^24)
   localparam int STORE_PTR_W = 24;

   // queue depths
   localparam int CMD_DEPTH = 4;
   localparam int RSP_DEPTH = 2;

   // sheet index field
   localparam int SHEET_INDEX_W = 5;

   // configuration port
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 11;
   localparam logic [CSR_INDEX_W-1:0] CSR_SCREEN_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SCREEN_HEIGHT = 1'b1;
   localparam logic [10:0] SCREEN_WIDTH_RESET  = 11'd320;
   localparam logic [10:0] SCREEN_HEIGHT_RESET = 11'd240;

   // operation codes
   localparam logic [1:0] OP_LOAD = 2'd0;
   localparam logic [1:0] OP_DRAW = 2'd1;
   localparam logic [1:0] OP_STEP = 2'd2;

   typedef struct packed {
      logic [1:0]               operation;
      logic signed [11:0]       x_pos;
      logic signed [11:0]       y_pos;
      logic [9:0]               rect_width;
      logic [9:0]               rect_height;
      logic [9:0]               source_x;
      logic [9:0]               source_y;
      logic [SHEET_INDEX_W-1:0] sheet_index;
      logic [10:0]              sheet_width;
      logic [20:0]              sheet_base;
   } req_item_type;

   typedef struct packed {
      logic [20:0] source_address;
      logic [19:0] dest_address;
      logic        row_end;
      logic        last;
   } rsp_item_type;

   // what the front hands to the walker
   typedef enum logic [1:0] {
      CMD_STEP,
      CMD_DRAW,
      CMD_HALT
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type           kind;
      logic [10:0]            clipped_width;
      logic [10:0]            rows;
      logic [STORE_PTR_W-1:0] source_pointer;
      logic [19:0]            dest_pointer;
      logic signed [11:0]     source_skip;
      logic [10:0]            dest_skip;
   } cmd_type;

endpackage

// File: design/cspb_fifo.sv
// ----------------------------------------------------------------------------
// cspb_fifo
// Small register queue with push/full and pop/empty on either side.
// ----------------------------------------------------------------------------
module cspb_fifo #(
   parameter type item_type = logic,
   parameter int  Depth     = 2
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   output logic     full,
   input  item_type push_item,
   input  logic     pop,
   output logic     empty,
   output item_type pop_item
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   item_type          mem_ff [Depth];
   logic [PtrW-1:0]   head_ff, head_in;
   logic [PtrW-1:0]   tail_ff, tail_in;
   logic [CntW-1:0]   count_ff, count_in;
   logic              wr, rd;

   assign full     = (count_ff == CntW'(Depth));
   assign empty    = (count_ff == '0);
   assign wr       = push && !full;
   assign rd       = pop && !empty;
   assign pop_item = mem_ff[head_ff];

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (wr) begin
         tail_in = (tail_ff == PtrW'(Depth - 1)) ? '0 : tail_ff + PtrW'(1);
      end
      if (rd) begin
         head_in = (head_ff == PtrW'(Depth - 1)) ? '0 : head_ff + PtrW'(1);
      end
      unique case ({wr, rd})
         2'b10: count_in = count_ff + CntW'(1);
         2'b01: count_in = count_ff - CntW'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr) begin
         mem_ff[tail_ff] <= push_item;
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (count_ff <= CntW'(Depth)) && ((count_ff == '0) == (head_ff == tail_ff) || full))
      else $error("fifo count out of step with pointers");
`endif

endmodule

// File: design/cspb_front.sv
// ----------------------------------------------------------------------------
// cspb_front
// Accepts items, keeps the sheet table, clips draws and works out start
// addresses and row skips through a six stage pipeline.
// ----------------------------------------------------------------------------
module cspb_front #(
   parameter int GfxStoreSize = cspb_pkg::GFX_STORE_SIZE,
   parameter int SheetCount   = cspb_pkg::SHEET_COUNT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   output logic                  req_full,
   input  cspb_pkg::req_item_type req_item,
   input  logic [10:0]           screen_width,
   input  logic [10:0]           screen_height,
   output logic                  cmd_push,
   input  logic                  cmd_full,
   output cspb_pkg::cmd_type     cmd_item
);

   localparam int SlotW      = (SheetCount > 1) ? $clog2(SheetCount) : 1;
   localparam int IndexCount = 2 ** cspb_pkg::SHEET_INDEX_W;
   localparam int SumW       = cspb_pkg::STORE_PTR_W;

   typedef struct packed {
      logic [10:0] width;
      logic [20:0] base;
   } sheet_entry_type;

   typedef struct packed {
      cspb_pkg::cmd_kind_type kind;
      logic [10:0] x2;
      logic [10:0] y2;
      logic [11:0] sx2;
      logic [11:0] sy2;
      logic [10:0] w2;
      logic [10:0] h2;
      logic [10:0] shw;
      logic [20:0] base;
   } clip_type;

   typedef struct packed {
      cspb_pkg::cmd_kind_type kind;
      logic [10:0]        x2;
      logic [10:0]        w2;
      logic [10:0]        h2;
      logic [11:0]        sx2;
      logic [20:0]        base;
      logic [22:0]        p_src;
      logic [21:0]        p_dst;
      logic signed [11:0] sskip;
      logic [10:0]        dskip;
   } prod_type;

   typedef struct packed {
      cspb_pkg::cmd_kind_type kind;
      logic [10:0]        w2;
      logic [10:0]        h2;
      logic signed [11:0] sskip;
      logic [10:0]        dskip;
      logic [SumW-1:0]    src_sum;
      logic [19:0]        dst;
   } addr_type;

   // sheet index taken modulo the table depth
   logic [SlotW-1:0] slot_map [IndexCount];
   for (genvar i = 0; i < IndexCount; i++) begin : g_slot
      assign slot_map[i] = SlotW'(i % SheetCount);
   end

   sheet_entry_type        sheet_mem_ff [SheetCount];
   logic [SlotW-1:0]       slot;
   logic                   advance, accept;

   logic                   s1_valid_ff, s1_valid_in;
   cspb_pkg::req_item_type s1_ff;
   sheet_entry_type        s1_entry_ff;
   logic                   s2_valid_ff, s3_valid_ff, s4_valid_ff, s5_valid_ff, s6_valid_ff;
   clip_type               s2_ff, s2_in;
   prod_type               s3_ff, s3_in;
   addr_type               s4_ff, s4_in;
   addr_type               s5_ff, s5_in;
   addr_type               s6_ff, s6_in;

   // one store-size subtraction per weight, four weights a stage
   function automatic logic [SumW-1:0] reduce4(input logic [SumW-1:0] v, input int low);
      logic [31:0] r;
      logic [31:0] m;
      r = 32'(v);
      for (int k = 3; k >= 0; k--) begin
         m = 32'(GfxStoreSize) << (k + low);
         if (r >= m) begin
            r = r - m;
         end
      end
      return r[SumW-1:0];
   endfunction

   assign slot     = slot_map[req_item.sheet_index];
   assign advance  = !s6_valid_ff || !cmd_full;
   assign req_full = !advance;
   assign accept   = req_push && advance;
   assign s1_valid_in = accept &&
                        (req_item.operation == cspb_pkg::OP_DRAW ||
                         req_item.operation == cspb_pkg::OP_STEP);

   always_ff @(posedge clock) begin
      if (accept && req_item.operation == cspb_pkg::OP_LOAD) begin
         sheet_mem_ff[slot] <= '{width: req_item.sheet_width, base: req_item.sheet_base};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_ff       <= req_item;
         s1_entry_ff <= sheet_mem_ff[slot];
      end
   end

   // clip against all four screen edges
   always_comb begin
      logic signed [13:0] x_e, y_e, w_e, h_e, sw_e, sh_e;
      logic signed [13:0] w1, h1, w2, h2, sx2, sy2;
      x_e  = 14'(s1_ff.x_pos);
      y_e  = 14'(s1_ff.y_pos);
      w_e  = $signed({4'b0, s1_ff.rect_width});
      h_e  = $signed({4'b0, s1_ff.rect_height});
      sw_e = $signed({3'b0, screen_width});
      sh_e = $signed({3'b0, screen_height});
      w1   = (w_e + x_e > sw_e) ? sw_e - x_e : w_e;
      h1   = (h_e + y_e > sh_e) ? sh_e - y_e : h_e;
      sx2  = $signed({4'b0, s1_ff.source_x});
      sy2  = $signed({4'b0, s1_ff.source_y});
      w2   = w1;
      h2   = h1;
      s2_in.x2 = x_e[10:0];
      s2_in.y2 = y_e[10:0];
      if (x_e < 0) begin
         sx2 = sx2 - x_e;
         w2  = w1 + x_e;
         s2_in.x2 = '0;
      end
      if (y_e < 0) begin
         sy2 = sy2 - y_e;
         h2  = h1 + y_e;
         s2_in.y2 = '0;
      end
      s2_in.sx2  = sx2[11:0];
      s2_in.sy2  = sy2[11:0];
      s2_in.w2   = w2[10:0];
      s2_in.h2   = h2[10:0];
      s2_in.shw  = s1_entry_ff.width;
      s2_in.base = s1_entry_ff.base;
      priority if (s1_ff.operation == cspb_pkg::OP_STEP) begin
         s2_in.kind = cspb_pkg::CMD_STEP;
      end else if (w2 <= 0 || h2 <= 0) begin
         s2_in.kind = cspb_pkg::CMD_HALT;
      end else begin
         s2_in.kind = cspb_pkg::CMD_DRAW;
      end
   end

   always_comb begin
      s3_in.kind  = s2_ff.kind;
      s3_in.x2    = s2_ff.x2;
      s3_in.w2    = s2_ff.w2;
      s3_in.h2    = s2_ff.h2;
      s3_in.sx2   = s2_ff.sx2;
      s3_in.base  = s2_ff.base;
      s3_in.p_src = 23'(s2_ff.shw) * 23'(s2_ff.sy2);
      s3_in.p_dst = 22'(screen_width) * 22'(s2_ff.y2);
      s3_in.sskip = $signed({1'b0, s2_ff.shw}) - $signed({1'b0, s2_ff.w2});
      s3_in.dskip = screen_width - s2_ff.w2;
   end

   always_comb begin
      logic [21:0] dst_full;
      dst_full        = 22'(s3_ff.x2) + s3_ff.p_dst;
      s4_in.kind      = s3_ff.kind;
      s4_in.w2        = s3_ff.w2;
      s4_in.h2        = s3_ff.h2;
      s4_in.sskip     = s3_ff.sskip;
      s4_in.dskip     = s3_ff.dskip;
      s4_in.src_sum   = SumW'(s3_ff.sx2) + SumW'(s3_ff.p_src) + SumW'(s3_ff.base);
      s4_in.dst       = dst_full[19:0];
   end

   always_comb begin
      s5_in         = s4_ff;
      s5_in.src_sum = reduce4(s4_ff.src_sum, 4);
      s6_in         = s5_ff;
      s6_in.src_sum = reduce4(s5_ff.src_sum, 0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
         s6_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
         s5_valid_ff <= s4_valid_ff;
         s6_valid_ff <= s5_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_ff <= s2_in;
         s3_ff <= s3_in;
         s4_ff <= s4_in;
         s5_ff <= s5_in;
         s6_ff <= s6_in;
      end
   end

   assign cmd_push                = s6_valid_ff;
   assign cmd_item.kind           = s6_ff.kind;
   assign cmd_item.clipped_width  = s6_ff.w2;
   assign cmd_item.rows           = s6_ff.h2;
   assign cmd_item.source_pointer = s6_ff.src_sum;
   assign cmd_item.dest_pointer   = s6_ff.dst;
   assign cmd_item.source_skip    = s6_ff.sskip;
   assign cmd_item.dest_skip      = s6_ff.dskip;

`ifndef SYNTHESIS
   // step items may carry unknown sheet data, so compare with case equality
   a_hold_when_blocked: assert property (@(posedge clock) disable iff (reset)
      (s6_valid_ff && cmd_full) |=> (s6_valid_ff && (s6_ff === $past(s6_ff))))
      else $error("front output changed while the command queue was full");

   a_draw_in_range: assert property (@(posedge clock) disable iff (reset)
      (s6_valid_ff && s6_ff.kind == cspb_pkg::CMD_DRAW) |->
         (s6_ff.src_sum < SumW'(GfxStoreSize) && s6_ff.w2 != '0 && s6_ff.h2 != '0))
      else $error("draw command with unreduced pointer or empty rectangle");
`endif

endmodule

// File: design/cspb_back.sv
// ----------------------------------------------------------------------------
// cspb_back
// Walks the clipped rectangle: one source and destination address pair for
// each step command while a draw is in progress.
// ----------------------------------------------------------------------------
module cspb_back #(
   parameter int GfxStoreSize = cspb_pkg::GFX_STORE_SIZE
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   cmd_empty,
   output logic                   cmd_pop,
   input  cspb_pkg::cmd_type      cmd_item,
   input  logic                   rsp_full,
   output logic                   rsp_push,
   output cspb_pkg::rsp_item_type rsp_item
);

   localparam int PtrW  = $clog2(GfxStoreSize);
   localparam int WalkW = PtrW + 2;
   localparam int ExtW  = (PtrW > 21) ? PtrW : 21;
   localparam logic signed [WalkW-1:0] StoreSize = WalkW'(GfxStoreSize);

   logic               busy_ff, busy_in;
   logic [10:0]        width_ff, width_in;
   logic [10:0]        cols_ff, cols_in;
   logic [10:0]        rows_ff, rows_in;
   logic [PtrW-1:0]    sptr_ff, sptr_in;
   logic [19:0]        dptr_ff, dptr_in;
   logic signed [11:0] sskip_ff, sskip_in;
   logic [10:0]        dskip_ff, dskip_in;

   logic                    row_end, last_pixel;
   logic signed [WalkW-1:0] src_raw, src_wrap;
   logic [19:0]             dst_next;
   logic [ExtW-1:0]         sptr_ext;

   assign row_end    = (cols_ff <= 11'd1);
   assign last_pixel = row_end && (rows_ff <= 11'd1);

   // next source address, wrapped once either way around the store
   always_comb begin
      logic signed [WalkW-1:0] skip_s;
      skip_s  = row_end ? WalkW'(sskip_ff) : '0;
      src_raw = $signed({2'b00, sptr_ff}) + $signed(WalkW'(1)) + skip_s;
      priority if (src_raw < 0) begin
         src_wrap = src_raw + StoreSize;
      end else if (src_raw >= StoreSize) begin
         src_wrap = src_raw - StoreSize;
      end else begin
         src_wrap = src_raw;
      end
   end

   assign dst_next = dptr_ff + 20'd1 + (row_end ? {9'b0, dskip_ff} : 20'd0);

   assign sptr_ext                = ExtW'(sptr_ff);
   assign rsp_item.source_address = sptr_ext[20:0];
   assign rsp_item.dest_address   = dptr_ff;
   assign rsp_item.row_end        = row_end;
   assign rsp_item.last           = last_pixel;

   always_comb begin
      busy_in  = busy_ff;
      width_in = width_ff;
      cols_in  = cols_ff;
      rows_in  = rows_ff;
      sptr_in  = sptr_ff;
      dptr_in  = dptr_ff;
      sskip_in = sskip_ff;
      dskip_in = dskip_ff;
      cmd_pop  = 1'b0;
      rsp_push = 1'b0;
      if (!cmd_empty) begin
         unique case (cmd_item.kind)
            cspb_pkg::CMD_DRAW: begin
               cmd_pop  = 1'b1;
               busy_in  = 1'b1;
               width_in = cmd_item.clipped_width;
               cols_in  = cmd_item.clipped_width;
               rows_in  = cmd_item.rows;
               sptr_in  = cmd_item.source_pointer[PtrW-1:0];
               dptr_in  = cmd_item.dest_pointer;
               sskip_in = cmd_item.source_skip;
               dskip_in = cmd_item.dest_skip;
            end
            cspb_pkg::CMD_HALT: begin
               cmd_pop = 1'b1;
               busy_in = 1'b0;
            end
            cspb_pkg::CMD_STEP: begin
               // a step with nothing in progress is dropped
               if (!busy_ff) begin
                  cmd_pop = 1'b1;
               end else if (!rsp_full) begin
                  cmd_pop  = 1'b1;
                  rsp_push = 1'b1;
                  sptr_in  = src_wrap[PtrW-1:0];
                  dptr_in  = dst_next;
                  if (!row_end) begin
                     cols_in = cols_ff - 11'd1;
                  end else if (last_pixel) begin
                     cols_in = '0;
                     rows_in = '0;
                     busy_in = 1'b0;
                  end else begin
                     cols_in = width_ff;
                     rows_in = rows_ff - 11'd1;
                  end
               end
            end
            default: begin
               cmd_pop = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      width_ff <= width_in;
      cols_ff  <= cols_in;
      rows_ff  <= rows_in;
      sptr_ff  <= sptr_in;
      dptr_ff  <= dptr_in;
      sskip_ff <= sskip_in;
      dskip_ff <= dskip_in;
   end

`ifndef SYNTHESIS
   a_push_only_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_push |-> (busy_ff && cmd_pop && !rsp_full))
      else $error("pixel produced with no draw in progress");

   a_last_ends_draw: assert property (@(posedge clock) disable iff (reset)
      (rsp_push && rsp_item.last) |=> !busy_ff)
      else $error("draw still running after its last pixel");
`endif

endmodule

// File: design/clipped_sprite_blit_addresser.sv
// ----------------------------------------------------------------------------
// clipped_sprite_blit_addresser
// Sprite blit address generator with clipping against the screen.
// ----------------------------------------------------------------------------
// Usage:
//   req_* is a queue input: an item (load sheet entry, start draw, step) is
//   taken at an edge with req_push high and req_full low. rsp_* is a queue
//   output: the oldest pixel item sits on rsp_item while rsp_empty is low and
//   leaves at an edge with rsp_pop high. csr_* writes screen width (index 0)
//   or screen height (index 1), one register per write, only while idle; the
//   user must ensure it, the block does not. Throughput is one item per
//   cycle while req_full is low. A step item reaches rsp_item through six
//   front stages (table read, clip, multiply, sum, two store-wrap reduction
//   stages), then the command queue and the walker. Load items and steps with
//   no draw in progress give no item. When rsp_pop is held low the result
//   queue fills, the walker holds, the command queue fills and req_full
//   rises; nothing is lost. Reset empties both queues, stops any draw and
//   sets the screen size to 320 by 240. The sheet table is not cleared:
//   drawing from an entry that was never loaded gives undefined addresses.
// ----------------------------------------------------------------------------
module clipped_sprite_blit_addresser #(
   parameter int GfxStoreSize = cspb_pkg::GFX_STORE_SIZE,
   parameter int SheetCount   = cspb_pkg::SHEET_COUNT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_push,
   output logic                                req_full,
   input  cspb_pkg::req_item_type              req_item,
   output logic                                rsp_empty,
   input  logic                                rsp_pop,
   output cspb_pkg::rsp_item_type              rsp_item,
   input  logic                                csr_write_enable,
   input  logic [cspb_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [cspb_pkg::CSR_DATA_W-1:0]     csr_data
);

   logic [10:0]            screen_width_ff, screen_width_in;
   logic [10:0]            screen_height_ff, screen_height_in;

   logic                   front_push, front_full;
   cspb_pkg::cmd_type      front_item;
   logic                   cmd_empty, cmd_pop;
   cspb_pkg::cmd_type      cmd_item;
   logic                   walk_push, walk_full;
   cspb_pkg::rsp_item_type walk_item;

   always_comb begin
      screen_width_in  = screen_width_ff;
      screen_height_in = screen_height_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            cspb_pkg::CSR_SCREEN_WIDTH:  screen_width_in  = csr_data;
            cspb_pkg::CSR_SCREEN_HEIGHT: screen_height_in = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         screen_width_ff  <= cspb_pkg::SCREEN_WIDTH_RESET;
         screen_height_ff <= cspb_pkg::SCREEN_HEIGHT_RESET;
      end else begin
         screen_width_ff  <= screen_width_in;
         screen_height_ff <= screen_height_in;
      end
   end

   cspb_front #(
      .GfxStoreSize (GfxStoreSize),
      .SheetCount   (SheetCount)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_item      (req_item),
      .screen_width  (screen_width_ff),
      .screen_height (screen_height_ff),
      .cmd_push      (front_push),
      .cmd_full      (front_full),
      .cmd_item      (front_item)
   );

   cspb_fifo #(
      .item_type (cspb_pkg::cmd_type),
      .Depth     (cspb_pkg::CMD_DEPTH)
   ) u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (front_push),
      .full      (front_full),
      .push_item (front_item),
      .pop       (cmd_pop),
      .empty     (cmd_empty),
      .pop_item  (cmd_item)
   );

   cspb_back #(
      .GfxStoreSize (GfxStoreSize)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_empty (cmd_empty),
      .cmd_pop   (cmd_pop),
      .cmd_item  (cmd_item),
      .rsp_full  (walk_full),
      .rsp_push  (walk_push),
      .rsp_item  (walk_item)
   );

   cspb_fifo #(
      .item_type (cspb_pkg::rsp_item_type),
      .Depth     (cspb_pkg::RSP_DEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (walk_push),
      .full      (walk_full),
      .push_item (walk_item),
      .pop       (rsp_pop),
      .empty     (rsp_empty),
      .pop_item  (rsp_item)
   );

endmodule

// File: tb/cspb_pixel_checker.sv
// ----------------------------------------------------------------------------
// cspb_pixel_checker
// Watches the item, pixel and register ports of the sprite blit addresser,
// keeps its own copy of the sheet table, screen size and walk state, and
// compares every popped pixel item with the oldest predicted one.
// ----------------------------------------------------------------------------
module cspb_pixel_checker
   import cspb_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_push,
   input  logic                   req_full,
   input  req_item_type           req_item,
   input  logic                   rsp_empty,
   input  logic                   rsp_pop,
   input  rsp_item_type           rsp_item,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   output int                     fail_count,
   output int                     pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [10:0]        screen_w;
   logic [10:0]        screen_h;
   logic [10:0]        sheet_w [SHEET_COUNT];
   logic [20:0]        sheet_b [SHEET_COUNT];
   logic               drawing;
   logic [10:0]        span_w;
   logic [10:0]        cols_left;
   logic [10:0]        rows_left;
   logic [20:0]        src_ptr;
   logic [19:0]        dst_ptr;
   logic signed [11:0] src_skip;
   logic [10:0]        dst_skip;
   rsp_item_type       pixels [$];
   int                 errors = 0;

   assign fail_count = errors;

   function automatic logic [20:0] store_wrap(input longint v);
      longint r;
      r = v % GFX_STORE_SIZE;
      if (r < 0) r += GFX_STORE_SIZE;
      return r[20:0];
   endfunction

   task automatic check_field(input string name, input logic [20:0] want,
                              input logic [20:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %h got %h", $time, name, want, got);
         errors++;
      end
   endtask

   task automatic predict_item(input req_item_type it);
      int           x, y, w, h, sx, sy, shw, sw, sh;
      longint       src;
      rsp_item_type px;
      case (it.operation)
         OP_LOAD: begin
            sheet_w[it.sheet_index] = it.sheet_width;
            sheet_b[it.sheet_index] = it.sheet_base;
         end
         OP_DRAW: begin
            x   = $signed(it.x_pos);
            y   = $signed(it.y_pos);
            w   = it.rect_width;
            h   = it.rect_height;
            sx  = it.source_x;
            sy  = it.source_y;
            sw  = screen_w;
            sh  = screen_h;
            shw = sheet_w[it.sheet_index];
            // clip right and bottom first, then shift the source corner
            if (w + x > sw) w = sw - x;
            if (x < 0) begin
               sx -= x;
               w  += x;
               x   = 0;
            end
            if (h + y > sh) h = sh - y;
            if (y < 0) begin
               sy -= y;
               h  += y;
               y   = 0;
            end
            if (w <= 0 || h <= 0) begin
               drawing = 1'b0;
            end else begin
               src = longint'(sx) + longint'(shw) * sy + longint'(sheet_b[it.sheet_index]);
               span_w    = w[10:0];
               cols_left = w[10:0];
               rows_left = h[10:0];
               src_ptr   = store_wrap(src);
               dst_ptr   = 20'(x + sw * y);
               src_skip  = 12'(shw - w);
               dst_skip  = 11'(sw - w);
               drawing   = 1'b1;
            end
         end
         OP_STEP: begin
            if (drawing) begin
               px.source_address = src_ptr;
               px.dest_address   = dst_ptr;
               px.row_end        = (cols_left <= 1);
               px.last           = px.row_end && (rows_left <= 1);
               pixels.push_back(px);
               if (!px.row_end) begin
                  src_ptr   = store_wrap(longint'(src_ptr) + 1);
                  dst_ptr   = dst_ptr + 20'd1;
                  cols_left = cols_left - 11'd1;
               end else begin
                  src_ptr   = store_wrap(longint'(src_ptr) + 1 + src_skip);
                  dst_ptr   = dst_ptr + 20'd1 + dst_skip;
                  cols_left = span_w;
                  rows_left = rows_left - 11'd1;
                  if (px.last) begin
                     rows_left = '0;
                     cols_left = '0;
                     drawing   = 1'b0;
                  end
               end
            end
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      rsp_item_type want;
      if (reset) begin
         screen_w  = SCREEN_WIDTH_RESET;
         screen_h  = SCREEN_HEIGHT_RESET;
         drawing   = 1'b0;
         span_w    = '0;
         cols_left = '0;
         rows_left = '0;
         src_ptr   = '0;
         dst_ptr   = '0;
         src_skip  = '0;
         dst_skip  = '0;
         pixels.delete();
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (pixels.size() == 0) begin
               $display("%0t: pixel item with none expected, got %h", $time, rsp_item);
               errors++;
            end else begin
               want = pixels.pop_front();
               check_field("source_address", want.source_address, rsp_item.source_address);
               check_field("dest_address", 21'(want.dest_address), 21'(rsp_item.dest_address));
               check_field("row_end", 21'(want.row_end), 21'(rsp_item.row_end));
               check_field("last", 21'(want.last), 21'(rsp_item.last));
            end
         end
         if (csr_write_enable) begin
            if (csr_index == CSR_SCREEN_WIDTH) screen_w = csr_data;
            else if (csr_index == CSR_SCREEN_HEIGHT) screen_h = csr_data;
         end
         if (req_push && !req_full) predict_item(req_item);
      end
      pending_count <= pixels.size();
   end

endmodule

// File: tb/tb_clipped_sprite_blit_addresser.sv
// ----------------------------------------------------------------------------
// tb_clipped_sprite_blit_addresser
// Drives load, draw and step items into the sprite blit addresser over six
// screen sizes, the first four with random gaps on both channels; a directed
// opening covers the clipping corners, then random sprite runs and noise follow.
// ----------------------------------------------------------------------------
module tb_clipped_sprite_blit_addresser;
   timeunit 1ns;
   timeprecision 1ps;

   import cspb_pkg::*;

   localparam int         DRAIN_CYCLES = 16;
   localparam int         PHASE_ITEMS  = 275;
   localparam logic [1:0] OP_UNUSED    = 2'd3;

   logic                   clock            = 1'b0;
   logic                   reset            = 1'b1;
   logic                   req_push         = 1'b0;
   logic                   req_full;
   req_item_type           req_item         = '0;
   logic                   rsp_empty;
   logic                   rsp_pop          = 1'b0;
   rsp_item_type           rsp_item;
   logic                   csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index        = '0;
   logic [CSR_DATA_W-1:0]  csr_data         = '0;
   int                     fail_count;
   int                     pending_count;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int items_sent    = 0;
   int screen_w      = 320;
   int screen_h      = 240;
   bit sheet_loaded [SHEET_COUNT];

   clipped_sprite_blit_addresser DUT (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_item         (req_item),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_item         (rsp_item),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   cspb_pixel_checker u_pixel_checker (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_item         (req_item),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_item         (rsp_item),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .fail_count       (fail_count),
      .pending_count    (pending_count)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      rsp_pop <= ($urandom_range(99) >= recv_idle_pct);
   end

   function automatic req_item_type item_of(input logic [1:0] op, input int x, input int y,
                                            input int w, input int h, input int sx,
                                            input int sy, input int idx, input int shw,
                                            input int base);
      req_item_type it;
      it.operation   = op;
      it.x_pos       = 12'(x);
      it.y_pos       = 12'(y);
      it.rect_width  = 10'(w);
      it.rect_height = 10'(h);
      it.source_x    = 10'(sx);
      it.source_y    = 10'(sy);
      it.sheet_index = 5'(idx);
      it.sheet_width = 11'(shw);
      it.sheet_base  = 21'(base);
      return it;
   endfunction

   function automatic req_item_type random_item(input logic [1:0] op);
      logic [127:0] noise;
      req_item_type it;
      noise = {$urandom, $urandom, $urandom, $urandom};
      it = noise[$bits(req_item_type)-1:0];
      it.operation = op;
      return it;
   endfunction

   task automatic send_item(input req_item_type it);
      // a draw never reads a sheet entry that was never loaded
      if (it.operation == OP_DRAW) begin
         while (!sheet_loaded[it.sheet_index]) it.sheet_index = 5'($urandom_range(31));
      end
      while ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_item <= it;
      @(posedge clock);
      while (req_full) @(posedge clock);
      items_sent++;
      if (it.operation == OP_LOAD) sheet_loaded[it.sheet_index] = 1'b1;
   endtask

   task automatic drain();
      req_push <= 1'b0;
      do begin
         while (pending_count != 0) @(posedge clock);
         repeat (DRAIN_CYCLES) @(posedge clock);
      end while (pending_count != 0);
   endtask

   task automatic write_screen(input int w, input int h);
      drain();
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_SCREEN_WIDTH;
      csr_data         <= 11'(w);
      @(posedge clock);
      csr_index        <= CSR_SCREEN_HEIGHT;
      csr_data         <= 11'(h);
      @(posedge clock);
      csr_write_enable <= 1'b0;
      screen_w = w;
      screen_h = h;
   endtask

   // one sprite: maybe a load, a draw near or across the screen, then its steps
   task automatic send_sprite_run();
      req_item_type it;
      int           w, h, steps, r;
      if ($urandom_range(9) < 3) send_item(random_item(OP_LOAD));
      it = random_item(OP_DRAW);
      w = ($urandom_range(19) == 0) ? $urandom_range(40, 1) : $urandom_range(8, 1);
      h = $urandom_range(6, 1);
      it.rect_width  = 10'(w);
      it.rect_height = 10'(h);
      r = $urandom_range(9);
      if (r < 6) begin
         it.x_pos = 12'($urandom_range(screen_w - 1));
         it.y_pos = 12'($urandom_range(screen_h - 1));
      end else if (r < 9) begin
         it.x_pos = 12'(int'($urandom_range(screen_w + w + 1)) - w - 1);
         it.y_pos = 12'(int'($urandom_range(screen_h + h + 1)) - h - 1);
      end
      send_item(it);
      steps = w * h + $urandom_range(2);
      for (int i = 0; i < steps; i++) begin
         r = $urandom_range(99);
         // loads and fresh draws landing in the middle of a sprite
         if (r < 3) send_item(random_item(OP_LOAD));
         else if (r < 5) send_item(random_item(OP_DRAW));
         send_item(random_item(OP_STEP));
      end
   endtask

   initial begin
      int           sw_list [6] = '{320, 1024, 1, 37, 1024, 200};
      int           sh_list [6] = '{240, 1024, 1, 9, 1, 1024};
      int           phase_end;
      bit           paused;
      req_item_type step_cmd;
      step_cmd = item_of(OP_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      for (int p = 0; p < 6; p++) begin
         send_idle_pct = (p < 2) ? 31 : (p < 4) ? 71 : 0;
         recv_idle_pct = (p < 2) ? 71 : (p < 4) ? 31 : 0;
         if (p == 0) begin
            send_item(item_of(OP_LOAD, 0, 0, 0, 0, 0, 0, 0, 1024, 0));
            send_item(item_of(OP_LOAD, 0, 0, 0, 0, 0, 0, 31, 2047, 21'h1FFFFF));
            send_item(item_of(OP_LOAD, 0, 0, 0, 0, 0, 0, 5, 0, 4096));
            // step with nothing drawing, then the unused code
            send_item(step_cmd);
            send_item(item_of(OP_UNUSED, 0, 0, 0, 0, 0, 0, 0, 0, 0));
            // far top-left, nothing left after clipping
            send_item(item_of(OP_DRAW, -2048, -2048, 1023, 1023, 0, 0, 0, 0, 0));
            // bottom-right corner, source address wraps
            send_item(item_of(OP_DRAW, 318, 238, 4, 3, 1023, 1023, 31, 0, 0));
            repeat (5) send_item(step_cmd);
            // top-left corner moves the source corner
            send_item(item_of(OP_DRAW, -3, -2, 5, 4, 0, 0, 0, 0, 0));
            repeat (2) send_item(step_cmd);
            send_item(item_of(OP_LOAD, 0, 0, 0, 0, 0, 0, 0, 7, 100));
            repeat (2) send_item(step_cmd);
            // sheet narrower than the sprite, row skip goes negative
            send_item(item_of(OP_DRAW, 0, 0, 3, 2, 1023, 0, 5, 0, 0));
            repeat (2) send_item(step_cmd);
            // empty draw drops the sprite in progress
            send_item(item_of(OP_DRAW, 2047, 5, 1, 1, 0, 0, 31, 0, 0));
            send_item(step_cmd);
            send_item(item_of(OP_DRAW, 10, 10, 0, 5, 0, 0, 0, 0, 0));
            send_item(item_of(OP_DRAW, 319, 239, 1023, 1023, 0, 0, 31, 0, 0));
            send_item(step_cmd);
         end else begin
            write_screen(sw_list[p], sh_list[p]);
         end
         phase_end = (p + 1) * PHASE_ITEMS;
         paused = 1'b0;
         while (items_sent < phase_end) begin
            if (!paused && items_sent >= phase_end - PHASE_ITEMS / 2) begin
               drain();
               paused = 1'b1;
            end
            if ($urandom_range(3) != 0) send_sprite_run();
            else send_item(random_item(2'($urandom_range(3))));
         end
      end
      drain();
      if (fail_count == 0 && pending_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("timeout with %0d pixel items outstanding", pending_count);
      $display("*** FAILED ***");
      $finish;
   end

endmodule

// File: sim.f
design/cspb_pkg.sv
design/cspb_fifo.sv
design/cspb_front.sv
design/cspb_back.sv
design/clipped_sprite_blit_addresser.sv
tb/cspb_pixel_checker.sv
tb/tb_clipped_sprite_blit_addresser.sv
